// ===== rtl/assert_macros.svh =====
// Assertion helpers for the coalescer checker.
// Each macro needs signal clk, and all but ASSERT_NEXT_ALWAYS rst_n, in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tac_pkg;

  localparam int MAX_AXES        = 5;
  localparam int FIELD_SLOTS     = 5;
  localparam int AXIS_LIMIT      = (MAX_AXES < FIELD_SLOTS) ? MAX_AXES : FIELD_SLOTS;
  localparam int RANK_MIN        = 2;
  localparam int AXIS_W          = 3;
  localparam int SIZE_W          = 32;
  localparam int NUM_MUL_STG     = FIELD_SLOTS - 1;
  localparam int TAC_QUEUE_DEPTH = 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef logic [AXIS_W-1:0] axis_t;
  typedef logic [SIZE_W-1:0] size_t;

  typedef struct packed {
    axis_t                   rank;
    axis_t [FIELD_SLOTS-1:0] axis;
    size_t [FIELD_SLOTS-1:0] size;
  } desc_t;

  // Classification produced by the front end.
  typedef struct packed {
    logic                    ok;
    axis_t                   groups;
    logic [FIELD_SLOTS-1:0]  merge;    // input axis i joins the group of axis i-1
    logic [FIELD_SLOTS-1:0]  grp_end;  // input axis i closes its group
    axis_t [FIELD_SLOTS-1:0] grp_idx;  // group of input axis i
    axis_t [FIELD_SLOTS-1:0] gorder;   // i-th group in output order
  } cls_t;

  typedef struct packed {
    desc_t d;
    cls_t  c;
  } work_t;

  typedef struct packed {
    work_t                   w;
    size_t [FIELD_SLOTS-1:0] prod;     // running product ending at input axis i
  } stg_t;

  typedef struct packed {
    logic                    status;
    axis_t                   merged_rank;
    axis_t [FIELD_SLOTS-1:0] merged_axis;
    size_t [FIELD_SLOTS-1:0] merged_size;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/tac_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tac_in_if import tac_pkg::*; ();
  logic  valid;
  logic  ready;
  axis_t rank;
  axis_t axis_0;
  axis_t axis_1;
  axis_t axis_2;
  axis_t axis_3;
  axis_t axis_4;
  size_t size_0;
  size_t size_1;
  size_t size_2;
  size_t size_3;
  size_t size_4;

  modport source (
    output valid, rank, axis_0, axis_1, axis_2, axis_3, axis_4,
           size_0, size_1, size_2, size_3, size_4,
    input  ready
  );

  modport sink (
    input  valid, rank, axis_0, axis_1, axis_2, axis_3, axis_4,
           size_0, size_1, size_2, size_3, size_4,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tac_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tac_out_if import tac_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  status;
  axis_t merged_rank;
  axis_t merged_axis_0;
  axis_t merged_axis_1;
  axis_t merged_axis_2;
  axis_t merged_axis_3;
  axis_t merged_axis_4;
  size_t merged_size_0;
  size_t merged_size_1;
  size_t merged_size_2;
  size_t merged_size_3;
  size_t merged_size_4;

  modport source (
    output valid, status, merged_rank,
           merged_axis_0, merged_axis_1, merged_axis_2, merged_axis_3, merged_axis_4,
           merged_size_0, merged_size_1, merged_size_2, merged_size_3, merged_size_4,
    input  ready
  );

  modport sink (
    input  valid, status, merged_rank,
           merged_axis_0, merged_axis_1, merged_axis_2, merged_axis_3, merged_axis_4,
           merged_size_0, merged_size_1, merged_size_2, merged_size_3, merged_size_4,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Descriptor check and axis grouping; narrow logic, no arithmetic on sizes.
module tac_front import tac_pkg::*; (
  input  desc_t desc_i,
  output cls_t  cls_o
);

  always_comb begin
    logic                    rank_ok;
    logic                    perm_ok;
    logic [7:0]              used;
    axis_t                   pos [8];
    axis_t                   grp [8];
    axis_t                   gcount;
    axis_t                   cnt;
    axis_t                   g_cur;
    axis_t                   g_prev;
    logic [FIELD_SLOTS-1:0]  merge;
    logic [FIELD_SLOTS-1:0]  gend;
    axis_t [FIELD_SLOTS-1:0] gorder;

    rank_ok = (desc_i.rank >= AXIS_W'(RANK_MIN)) && (desc_i.rank <= AXIS_W'(AXIS_LIMIT));
    perm_ok = rank_ok;
    used    = '0;
    for (int j = 0; j < 8; j++) begin
      pos[j] = '0;
      grp[j] = '0;
    end

    // permutation check; pos[a] = output position of input axis a
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      if (AXIS_W'(i) < desc_i.rank) begin
        if (desc_i.axis[i] >= desc_i.rank || used[desc_i.axis[i]]) begin
          perm_ok = 1'b0;
        end
        used[desc_i.axis[i]] = 1'b1;
        pos[desc_i.axis[i]]  = AXIS_W'(i);
      end
    end

    // runs of input axes that stay adjacent in the output
    merge  = '0;
    gcount = AXIS_W'(1);
    for (int i = 1; i < FIELD_SLOTS; i++) begin
      if (perm_ok && AXIS_W'(i) < desc_i.rank) begin
        if ({1'b0, pos[i]} != ({1'b0, pos[i-1]} + 4'd1)) begin
          gcount = gcount + AXIS_W'(1);
        end else begin
          merge[i] = 1'b1;
        end
        grp[i] = gcount - AXIS_W'(1);
      end
    end

    gend = '0;
    for (int i = 0; i < FIELD_SLOTS - 1; i++) begin
      gend[i] = perm_ok && (AXIS_W'(i) < desc_i.rank) && !merge[i+1];
    end
    gend[FIELD_SLOTS-1] = perm_ok && (AXIS_W'(FIELD_SLOTS - 1) < desc_i.rank);

    // group order seen along the output positions
    gorder = '0;
    cnt    = '0;
    g_prev = '0;
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      g_cur = grp[desc_i.axis[i]];
      if (perm_ok && AXIS_W'(i) < desc_i.rank) begin
        if (i == 0 || g_cur != g_prev) begin
          if (cnt < AXIS_W'(FIELD_SLOTS)) begin
            gorder[cnt] = g_cur;
          end
          cnt = cnt + AXIS_W'(1);
        end
      end
      g_prev = g_cur;
    end

    cls_o.ok      = perm_ok && (cnt == gcount);
    cls_o.groups  = gcount;
    cls_o.merge   = merge;
    cls_o.grp_end = gend;
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      cls_o.grp_idx[i] = grp[i];
    end
    cls_o.gorder  = gorder;
  end

endmodule

`default_nettype wire

// ===== rtl/tac_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small register queue between front and back end.
module tac_queue import tac_pkg::*; #(
  parameter int DEPTH = TAC_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Size products: one 32x32 multiply per stage, then group select and
// output register.
module tac_back import tac_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  work_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  localparam int N = NUM_MUL_STG;

  stg_t seed;
  stg_t s_in  [1:N];
  stg_t s_nxt [1:N];
  stg_t st_r  [1:N];
  logic v_in  [1:N];
  logic v_r   [1:N];
  logic rdy   [1:N+1];

  logic out_v_r;
  res_t out_r;
  res_t res_nxt;

  always_comb begin
    seed         = '0;
    seed.w       = in_data;
    seed.prod[0] = in_data.d.size[0];
  end

  assign in_ready = rdy[1];

  for (genvar k = 1; k <= N; k++) begin : g_stg
    size_t mul_lo;

    if (k == 1) begin : g_first
      assign s_in[k] = seed;
      assign v_in[k] = in_valid;
    end else begin : g_next
      assign s_in[k] = st_r[k-1];
      assign v_in[k] = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];
    assign mul_lo = s_in[k].prod[k-1] * s_in[k].w.d.size[k];

    always_comb begin
      s_nxt[k]         = s_in[k];
      s_nxt[k].prod[k] = s_in[k].w.c.merge[k] ? mul_lo : s_in[k].w.d.size[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in[k]) begin
        st_r[k] <= s_nxt[k];
      end
    end
  end

  assign rdy[N+1] = !out_v_r || out_ready;

  // pick each group's product, then fill unused slots with the input fields
  always_comb begin
    size_t [FIELD_SLOTS-1:0] gsize;
    stg_t                    s;
    logic                    ok;

    s     = st_r[N];
    ok    = s.w.c.ok;
    gsize = '0;
    for (int g = 0; g < FIELD_SLOTS; g++) begin
      for (int k = 0; k < FIELD_SLOTS; k++) begin
        if (s.w.c.grp_end[k] && s.w.c.grp_idx[k] == AXIS_W'(g)) begin
          gsize[g] = s.prod[k];
        end
      end
    end

    res_nxt.status      = ok ? STATUS_OK : STATUS_BAD;
    res_nxt.merged_rank = ok ? s.w.c.groups : s.w.d.rank;
    for (int i = 0; i < FIELD_SLOTS; i++) begin
      if (ok && AXIS_W'(i) < s.w.c.groups) begin
        res_nxt.merged_axis[i] = s.w.c.gorder[i];
        res_nxt.merged_size[i] = gsize[i];
      end else begin
        res_nxt.merged_axis[i] = s.w.d.axis[i];
        res_nxt.merged_size[i] = s.w.d.size[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy[N+1]) begin
      out_v_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[N+1] && v_r[N]) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/transpose_axis_coalescer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Port      Dir  Payload
// -------   -------   ---  ------------------------------------------------
// input     in_desc   in   rank, axis_0..axis_4, size_0..size_4
// result    out_res   out  status, merged_rank, merged_axis_0..4,
//                          merged_size_0..4
//
// One descriptor per cycle while out_res.ready holds; each transfer gives
// exactly one result. A descriptor is written into the queue on the transfer
// edge, then passes four multiply stages (one 32x32 product each, the chained
// size multiplies set the depth) and the output register.
// rst_n is synchronous, active low; it empties queue and pipeline.
// Back-pressure ripples up the stage ready chain; the 2-entry queue lets
// the front keep taking transfers while the back end is stalled.
module transpose_axis_coalescer import tac_pkg::*; #(
  parameter int QUEUE_DEPTH = TAC_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  tac_in_if.sink    in_desc,
  tac_out_if.source out_res
);

  desc_t desc;
  cls_t  cls;
  work_t push_data;
  work_t pop_data;
  logic  pop_valid;
  logic  pop_ready;
  res_t  res;

  // gather the input fields into one descriptor
  assign desc.rank    = in_desc.rank;
  assign desc.axis[0] = in_desc.axis_0;
  assign desc.axis[1] = in_desc.axis_1;
  assign desc.axis[2] = in_desc.axis_2;
  assign desc.axis[3] = in_desc.axis_3;
  assign desc.axis[4] = in_desc.axis_4;
  assign desc.size[0] = in_desc.size_0;
  assign desc.size[1] = in_desc.size_1;
  assign desc.size[2] = in_desc.size_2;
  assign desc.size[3] = in_desc.size_3;
  assign desc.size[4] = in_desc.size_4;

  // front: validity check and grouping, no size math
  tac_front u_front (
    .desc_i (desc),
    .cls_o  (cls)
  );

  assign push_data.d = desc;
  assign push_data.c = cls;

  tac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_desc.valid),
    .push_ready (in_desc.ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: group products and result assembly
  tac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_data   (pop_data),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_data  (res)
  );

  assign out_res.status        = res.status;
  assign out_res.merged_rank   = res.merged_rank;
  assign out_res.merged_axis_0 = res.merged_axis[0];
  assign out_res.merged_axis_1 = res.merged_axis[1];
  assign out_res.merged_axis_2 = res.merged_axis[2];
  assign out_res.merged_axis_3 = res.merged_axis[3];
  assign out_res.merged_axis_4 = res.merged_axis[4];
  assign out_res.merged_size_0 = res.merged_size[0];
  assign out_res.merged_size_1 = res.merged_size[1];
  assign out_res.merged_size_2 = res.merged_size[2];
  assign out_res.merged_size_3 = res.merged_size[3];
  assign out_res.merged_size_4 = res.merged_size[4];

endmodule

`default_nettype wire

// ===== rtl/tac_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tac_chk import tac_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire logic  out_status,
  input wire axis_t out_merged_rank
);

  // transfers in flight: input transfers not yet answered
  logic [7:0] cnt_r, cnt_nxt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt_nxt = cnt_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_NEXT_ALWAYS(a_idle_after_reset, !rst_n, !out_valid, "result valid right after reset")
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ASSERT_IMPLY(a_no_orphan, out_valid, cnt_r != 8'd0, "result without an input transfer")
  `ASSERT_IMPLY(a_ok_rank, out_valid && out_status == STATUS_OK, (out_merged_rank != '0) && (out_merged_rank <= AXIS_W'(AXIS_LIMIT)), "merged rank out of range")

endmodule

bind transpose_axis_coalescer tac_chk u_tac_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_desc.valid),
  .in_ready        (in_desc.ready),
  .out_valid       (out_res.valid),
  .out_ready       (out_res.ready),
  .out_status      (out_res.status),
  .out_merged_rank (out_res.merged_rank)
);

`default_nettype wire
